// ----- hw/rtl/cart_pkg.sv -----
package cart_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int RETRY_W = 4;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_OUT_W = 4;
  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 200;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FATAL_ON_TIMEOUT = 2'd2;

  localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 16'd500;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd3;
  localparam logic FATAL_ON_TIMEOUT_RST = 1'b1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_MEAS_START = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MEAS_CANCEL = 3'd4;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PASSED   = 3'd1,
    EV_TRACKED  = 3'd2,
    EV_REJECTED = 3'd3,
    EV_RETRY    = 3'd4,
    EV_TIMEOUT  = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_PUSH,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SLOT_HOLD,
    SLOT_REMOVE,
    SLOT_APPEND,
    SLOT_RETRY
  } slot_op_t;

  typedef struct packed {
    logic [DATA_W-1:0]  sequence_num;
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  tag;
    logic [DATA_W-1:0]  last_sent;
    logic [RETRY_W-1:0] retries;
  } slot_t;

endpackage

// ----- hw/rtl/cumulative_ack_retry_tracker_top.sv -----
// Sequencing: an untracked push goes straight to the output stage. A tracked
// push first pops acknowledged head entries one per cycle, then appends; a tick
// pops likewise, then scans entries one per cycle through the shared subtractor.
// A new command is accepted only in idle, once the previous result is loaded.
// Reset: queue empty, counters zero, registers at 500 ms, 3 retries, fatal on.
module cumulative_ack_retry_tracker_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // command_kind, command_sequence, command_tag, ack_sequence, now_ms
  input  logic [cart_pkg::S_TDATA_W-1:0]      s_tdata,
  // func
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // event_sequence, event_kind, event_tag, fatal_timeout, in_flight_count,
  // saturation_total, retry_total, timeout_total, last_tracked_sequence
  output logic [cart_pkg::M_TDATA_W-1:0]      m_tdata,
  // event_res
  output logic [2:0]                          m_tuser,
  input  logic                                cfg_we,
  input  logic [cart_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cart_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = cart_pkg::DATA_W;
  localparam int KW = cart_pkg::KIND_W;

  cart_pkg::state_t state, state_next;
  logic [CNT_W-1:0] occ, occ_next;
  logic [CNT_W-1:0] scan, scan_next;

  logic          in_func;
  logic [KW-1:0] in_kind;
  logic [DW-1:0] in_seq, in_tag, in_ack, in_now;

  cart_pkg::event_t ev_res, ev_res_next;
  logic [DW-1:0] ev_seq, ev_seq_next;
  logic [KW-1:0] ev_kind, ev_kind_next;
  logic [DW-1:0] ev_tag, ev_tag_next;
  logic          ev_fatal, ev_fatal_next;

  logic [DW-1:0] saturations, saturations_next;
  logic [DW-1:0] retries_issued, retries_issued_next;
  logic [DW-1:0] timeouts_seen, timeouts_seen_next;
  logic [DW-1:0] newest_tracked, newest_tracked_next;

  logic [cart_pkg::TIMEOUT_W-1:0] ack_timeout_ms;
  logic [cart_pkg::RETRY_W-1:0]   max_retries;
  logic                           fatal_on_timeout;

  logic          f_func;
  logic [KW-1:0] f_kind;
  logic [DW-1:0] f_seq, f_tag, f_ack, f_now;

  cart_pkg::slot_op_t slot_op;
  logic [IDX_W-1:0]   slot_idx;
  logic [IDX_W-1:0]   rd_idx;
  cart_pkg::slot_t    slot_wr;
  cart_pkg::slot_t    slot_rd;

  logic [DW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_reached;

  logic              accept;
  logic              out_load;
  logic [CNT_W+3:0]  occ_ext;

  assign f_func = s_tuser;
  assign f_kind = s_tdata[2:0];
  assign f_seq  = s_tdata[34:3];
  assign f_tag  = s_tdata[66:35];
  assign f_ack  = s_tdata[98:67];
  assign f_now  = s_tdata[130:99];

  assign s_tready = (state == cart_pkg::ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign occ_ext = {4'b0, occ};

  assign rd_idx = (state == cart_pkg::ST_POP) ? '0 : scan[IDX_W-1:0];
  assign alu_a = (state == cart_pkg::ST_POP) ? in_ack : in_now;
  assign alu_b = (state == cart_pkg::ST_POP) ? slot_rd.sequence_num : slot_rd.last_sent;

  assign slot_wr = '{sequence_num: in_seq, kind: in_kind, tag: in_tag,
                     last_sent: in_now, retries: '0};

  cart_alu u_alu (
    .a       (alu_a),
    .b       (alu_b),
    .limit   (ack_timeout_ms),
    .diff    (alu_diff),
    .reached (alu_reached)
  );

  cart_slots #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk    (clk),
    .op     (slot_op),
    .idx    (slot_idx),
    .wr     (slot_wr),
    .now    (in_now),
    .rd_idx (rd_idx),
    .rd     (slot_rd)
  );

  always_comb begin
    state_next = state;
    occ_next = occ;
    scan_next = scan;
    ev_res_next = ev_res;
    ev_seq_next = ev_seq;
    ev_kind_next = ev_kind;
    ev_tag_next = ev_tag;
    ev_fatal_next = ev_fatal;
    saturations_next = saturations;
    retries_issued_next = retries_issued;
    timeouts_seen_next = timeouts_seen;
    newest_tracked_next = newest_tracked;
    slot_op = cart_pkg::SLOT_HOLD;
    slot_idx = rd_idx;
    out_load = 1'b0;

    unique case (state)
      cart_pkg::ST_IDLE: begin
        if (accept) begin
          ev_res_next = cart_pkg::EV_NONE;
          ev_seq_next = '0;
          ev_kind_next = '0;
          ev_tag_next = '0;
          ev_fatal_next = 1'b0;
          state_next = cart_pkg::ST_POP;
          if (f_func == cart_pkg::FUNC_PUSH) begin
            ev_seq_next = f_seq;
            ev_kind_next = f_kind;
            if (f_kind != cart_pkg::KIND_MEAS_START &&
                f_kind != cart_pkg::KIND_MEAS_CANCEL) begin
              ev_res_next = cart_pkg::EV_PASSED;
              state_next = cart_pkg::ST_DONE;
            end
          end
        end
      end
      cart_pkg::ST_POP: begin
        if (occ != '0 && !alu_diff[DW-1]) begin
          slot_op = cart_pkg::SLOT_REMOVE;
          slot_idx = '0;
          occ_next = occ - 1'b1;
        end else if (in_func == cart_pkg::FUNC_PUSH) begin
          state_next = cart_pkg::ST_PUSH;
        end else begin
          scan_next = '0;
          state_next = cart_pkg::ST_SCAN;
        end
      end
      cart_pkg::ST_PUSH: begin
        if (occ == CNT_W'(QUEUE_DEPTH)) begin
          saturations_next = saturations + 1'b1;
          ev_res_next = cart_pkg::EV_REJECTED;
        end else begin
          slot_op = cart_pkg::SLOT_APPEND;
          slot_idx = occ[IDX_W-1:0];
          occ_next = occ + 1'b1;
          newest_tracked_next = in_seq;
          ev_res_next = cart_pkg::EV_TRACKED;
        end
        state_next = cart_pkg::ST_DONE;
      end
      cart_pkg::ST_SCAN: begin
        if (scan >= occ) begin
          state_next = cart_pkg::ST_DONE;
        end else if (alu_reached) begin
          ev_seq_next = slot_rd.sequence_num;
          ev_kind_next = slot_rd.kind;
          ev_tag_next = slot_rd.tag;
          if (slot_rd.retries < max_retries) begin
            slot_op = cart_pkg::SLOT_RETRY;
            retries_issued_next = retries_issued + 1'b1;
            ev_res_next = cart_pkg::EV_RETRY;
          end else begin
            slot_op = cart_pkg::SLOT_REMOVE;
            occ_next = occ - 1'b1;
            timeouts_seen_next = timeouts_seen + 1'b1;
            ev_fatal_next = fatal_on_timeout;
            ev_res_next = cart_pkg::EV_TIMEOUT;
          end
          state_next = cart_pkg::ST_DONE;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      cart_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = cart_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cart_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cart_pkg::ST_IDLE;
      occ <= '0;
      scan <= '0;
      saturations <= '0;
      retries_issued <= '0;
      timeouts_seen <= '0;
      newest_tracked <= '0;
      m_tvalid <= 1'b0;
      ack_timeout_ms <= cart_pkg::ACK_TIMEOUT_RST;
      max_retries <= cart_pkg::MAX_RETRIES_RST;
      fatal_on_timeout <= cart_pkg::FATAL_ON_TIMEOUT_RST;
    end else begin
      state <= state_next;
      occ <= occ_next;
      scan <= scan_next;
      saturations <= saturations_next;
      retries_issued <= retries_issued_next;
      timeouts_seen <= timeouts_seen_next;
      newest_tracked <= newest_tracked_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          cart_pkg::CFG_ACK_TIMEOUT: ack_timeout_ms <= cfg_data;
          cart_pkg::CFG_MAX_RETRIES: max_retries <= cfg_data[cart_pkg::RETRY_W-1:0];
          cart_pkg::CFG_FATAL_ON_TIMEOUT: fatal_on_timeout <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_func <= f_func;
      in_kind <= f_kind;
      in_seq <= f_seq;
      in_tag <= f_tag;
      in_ack <= f_ack;
      in_now <= f_now;
    end
    ev_res <= ev_res_next;
    ev_seq <= ev_seq_next;
    ev_kind <= ev_kind_next;
    ev_tag <= ev_tag_next;
    ev_fatal <= ev_fatal_next;
    if (out_load) begin
      m_tuser <= ev_res;
      m_tdata <= {newest_tracked, timeouts_seen, retries_issued, saturations,
                  occ_ext[cart_pkg::COUNT_OUT_W-1:0], ev_fatal, ev_tag, ev_kind, ev_seq};
    end
  end

endmodule

// ----- hw/rtl/cart_alu.sv -----
module cart_alu (
  input  logic [cart_pkg::DATA_W-1:0]    a,
  input  logic [cart_pkg::DATA_W-1:0]    b,
  input  logic [cart_pkg::TIMEOUT_W-1:0] limit,
  output logic [cart_pkg::DATA_W-1:0]    diff,
  output logic                           reached
);

  always_comb begin
    diff = a - b;
    reached = (diff[cart_pkg::DATA_W-1:cart_pkg::TIMEOUT_W] != '0) ||
              (diff[cart_pkg::TIMEOUT_W-1:0] >= limit);
  end

endmodule

// ----- hw/rtl/cart_slots.sv -----
module cart_slots #(
  parameter int QUEUE_DEPTH = 8,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                        clk,
  input  cart_pkg::slot_op_t          op,
  input  logic [IDX_W-1:0]            idx,
  input  cart_pkg::slot_t             wr,
  input  logic [cart_pkg::DATA_W-1:0] now,
  input  logic [IDX_W-1:0]            rd_idx,
  output cart_pkg::slot_t             rd
);

  cart_pkg::slot_t slots [QUEUE_DEPTH];
  cart_pkg::slot_t shifted [QUEUE_DEPTH];

  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
      shifted[j] = slots[j+1];
    end
    shifted[QUEUE_DEPTH-1] = '0;
  end

  assign rd = slots[rd_idx];

  always_ff @(posedge clk) begin
    unique case (op)
      cart_pkg::SLOT_REMOVE: begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          if (j >= int'(idx)) begin
            slots[j] <= shifted[j];
          end
        end
      end
      cart_pkg::SLOT_APPEND: begin
        slots[idx] <= wr;
      end
      cart_pkg::SLOT_RETRY: begin
        slots[idx].retries <= slots[idx].retries + 1'b1;
        slots[idx].last_sent <= now;
      end
      default: begin
      end
    endcase
  end

endmodule
